[src/signed_int_to_decimal_ascii_defines.svh]
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii assertion macros
// shared assertion forms for the decimal text converter
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH

// same-cycle implication
`define SID_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SID_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/sid_pkg.sv]
// ----------------------------------------------------------------------------
// sid_pkg
// constants, types and the double-dabble step for the decimal text converter
// ----------------------------------------------------------------------------
package sid_pkg;

   localparam int ValueWidth     = 32;
   localparam int DigitCount     = 10;
   localparam int DigitWidth     = 4;
   localparam int BcdWidth       = DigitCount * DigitWidth;
   localparam int DabbleStages   = 4;
   localparam int StepsPerStage  = ValueWidth / DabbleStages;
   localparam int IndexWidth     = $clog2(DigitCount);

   localparam logic [7:0] CharZero  = 8'd48;
   localparam logic [7:0] CharMinus = 8'd45;

   typedef struct packed {
      logic                  neg;
      logic [BcdWidth-1:0]   bcd;
      logic [ValueWidth-1:0] bin;
   } dabble_type;

   // shift-and-add-3 over one slice of the magnitude
   function automatic dabble_type dabble_slice(input dabble_type cur);
      dabble_type res;
      logic [DigitWidth-1:0] dig;
      res = cur;
      for (int s = 0; s < StepsPerStage; s++) begin
         for (int d = 0; d < DigitCount; d++) begin
            dig = res.bcd[d*DigitWidth +: DigitWidth];
            if (dig >= 4'd5) begin
               res.bcd[d*DigitWidth +: DigitWidth] = dig + 4'd3;
            end
         end
         {res.bcd, res.bin} = {res.bcd[BcdWidth-2:0], res.bin, 1'b0};
      end
      return res;
   endfunction

endpackage

[src/signed_int_to_decimal_ascii.sv]
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// signed 32-bit integer to decimal ascii text, one character per item
// ----------------------------------------------------------------------------
// Each value taken on req_ becomes a run of 1 to 11 characters on rsp_, a
// minus sign first for negative values, then the digits most significant
// first with leading zeros dropped; rsp_tlast marks the final character.
// A value passes an input register and four shift-and-add-3 stages before
// reaching the character serializer, which sends one character per cycle
// while rsp_tready allows it; a value gives 1 to 11 characters (e.g. 11 for
// -2147483648). The pipeline keeps accepting values while the serializer is
// busy until its stages fill.
// ----------------------------------------------------------------------------
`include "signed_int_to_decimal_ascii_defines.svh"

module signed_int_to_decimal_ascii (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic signed [31:0] req_tdata,   // value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,          // character
   output logic        rsp_tlast           // last
);
   import sid_pkg::*;

   localparam int LastStage = DabbleStages;

   logic [LastStage:0] pipe_valid_ff;
   logic [LastStage:0] pipe_ready;
   dabble_type         pipe_ff [0:LastStage];
   dabble_type         entry_in;

   logic                  busy_ff;
   logic                  sign_pend_ff;
   logic [BcdWidth-1:0]   digits_ff;
   logic [IndexWidth-1:0] idx_ff;
   logic [IndexWidth-1:0] top_in;

   logic       out_valid_ff;
   logic [7:0] out_char_ff;
   logic       out_last_ff;

   logic out_free;
   logic ser_ready;
   logic ser_load;
   logic ser_emit;

   assign out_free  = !out_valid_ff || rsp_tready;
   assign ser_emit  = busy_ff && out_free;
   assign ser_ready = !busy_ff || (ser_emit && !sign_pend_ff && idx_ff == '0);
   assign ser_load  = pipe_valid_ff[LastStage] && ser_ready;

   always_comb begin
      pipe_ready[LastStage] = !pipe_valid_ff[LastStage] || ser_ready;
      for (int k = 0; k < LastStage; k++) begin
         pipe_ready[k] = !pipe_valid_ff[k] || pipe_ready[k+1];
      end
   end

   assign req_tready = pipe_ready[0];

   // sign and two's complement magnitude
   always_comb begin
      entry_in.neg = req_tdata[ValueWidth-1];
      entry_in.bcd = '0;
      entry_in.bin = req_tdata[ValueWidth-1] ?
                     (ValueWidth'(0) - ValueWidth'(unsigned'(req_tdata))) :
                     ValueWidth'(unsigned'(req_tdata));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_valid_ff <= '0;
      end else begin
         if (pipe_ready[0]) begin
            pipe_valid_ff[0] <= req_tvalid;
         end
         for (int k = 1; k <= LastStage; k++) begin
            if (pipe_ready[k]) begin
               pipe_valid_ff[k] <= pipe_valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && pipe_ready[0]) begin
         pipe_ff[0] <= entry_in;
      end
      for (int k = 1; k <= LastStage; k++) begin
         if (pipe_ready[k] && pipe_valid_ff[k-1]) begin
            pipe_ff[k] <= dabble_slice(pipe_ff[k-1]);
         end
      end
   end

   // highest non-zero digit, zero gives one digit
   always_comb begin
      top_in = '0;
      for (int d = 1; d < DigitCount; d++) begin
         if (pipe_ff[LastStage].bcd[d*DigitWidth +: DigitWidth] != '0) begin
            top_in = IndexWidth'(d);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         sign_pend_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (ser_load) begin
            busy_ff      <= 1'b1;
            sign_pend_ff <= pipe_ff[LastStage].neg;
         end else if (ser_emit) begin
            if (sign_pend_ff) begin
               sign_pend_ff <= 1'b0;
            end else if (idx_ff == '0) begin
               busy_ff <= 1'b0;
            end
         end
         if (out_free) begin
            out_valid_ff <= busy_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ser_load) begin
         digits_ff <= pipe_ff[LastStage].bcd;
         idx_ff    <= top_in;
      end else if (ser_emit && !sign_pend_ff && idx_ff != '0) begin
         idx_ff <= idx_ff - 1'b1;
      end
      if (ser_emit) begin
         if (sign_pend_ff) begin
            out_char_ff <= CharMinus;
            out_last_ff <= 1'b0;
         end else begin
            out_char_ff <= CharZero + 8'(digits_ff[idx_ff*DigitWidth +: DigitWidth]);
            out_last_ff <= (idx_ff == '0);
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_char_ff;
   assign rsp_tlast  = out_last_ff;

   `SID_ASSERT_NOW(a_minus_not_last, clock, reset,
      out_valid_ff && out_char_ff == CharMinus, !out_last_ff,
      "minus sign flagged as last character")
   `SID_ASSERT_NOW(a_char_range, clock, reset, out_valid_ff,
      out_char_ff == CharMinus || (out_char_ff >= CharZero && out_char_ff <= CharZero + 8'd9),
      "character is neither minus nor digit")
   `SID_ASSERT_NOW(a_index_range, clock, reset, busy_ff,
      idx_ff < IndexWidth'(DigitCount), "digit index beyond digit store")
   `SID_ASSERT_NEXT(a_sign_once, clock, reset, busy_ff && sign_pend_ff && out_free,
      !sign_pend_ff, "minus sign sent more than once")

endmodule
